// ----- rtl/core/seven_segment_decimal_scanner_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the decimal scanner RTL.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DECIMAL_SCANNER_DEFINES_SVH
`define SEVEN_SEGMENT_DECIMAL_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SSDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SSDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SSDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/ssds_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal scanner package
// Widths, segment table, reciprocal constants and shared types.
// ----------------------------------------------------------------------------
package ssds_pkg;

	localparam int unsigned VALUE_W         = 14;
	localparam int unsigned DWELL_W         = 16;
	localparam int unsigned MASK_W          = 4;
	localparam int unsigned ENABLE_W        = 4;
	localparam int unsigned SEG_W           = 8;
	localparam int unsigned DIGIT_W         = 4;
	localparam int unsigned USED_W          = 3;
	localparam int unsigned BCD_DIGITS      = 5;
	localparam int unsigned PROD_W          = 32;
	localparam int unsigned DIGIT_COUNT_DEF = 4;
	localparam int unsigned APB_DATA_W      = 32;
	localparam int unsigned APB_ADDR_W      = 3;

	localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd25000;
	localparam logic [SEG_W-1:0]   POINT_BIT   = 8'h80;

	// segments a..g for digits 0..9; other codes stay dark
	localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// floor(v / 10^k) = (v * MUL) >> SHIFT, exact for every 14-bit v
	localparam int unsigned RECIP_MUL   [BCD_DIGITS] = '{1, 6554, 10486, 16778, 13422};
	localparam int unsigned RECIP_SHIFT [BCD_DIGITS] = '{0, 16, 20, 24, 27};

	typedef enum logic {
		REG_DWELL_TICKS = 1'b0,
		REG_POINT_MASK  = 1'b1
	} reg_idx_t;

	// converted load value: digits left-aligned, position 0 first
	typedef struct packed {
		logic [BCD_DIGITS-1:0][DIGIT_W-1:0] digit;
		logic [USED_W-1:0]                  used;
		logic                               clamped;
	} conv_t;

	function automatic int unsigned pow10(input int unsigned n);
		int unsigned r;
		r = 1;
		for (int unsigned i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ssds_if.sv -----
// ----------------------------------------------------------------------------
// Decimal scanner channels
// Valid/ready interfaces for the item input and the display result.
// ----------------------------------------------------------------------------
interface ssds_item_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [ssds_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ssds_result_if;
	logic                           valid;
	logic                           ready;
	logic [ssds_pkg::ENABLE_W-1:0]  digit_enable_n;
	logic [ssds_pkg::SEG_W-1:0]     segments;
	logic                           over_range;

	modport source (output valid, output digit_enable_n, output segments, output over_range,
		input ready);
	modport sink   (input valid, input digit_enable_n, input segments, input over_range,
		output ready);
endinterface

// ----- rtl/core/ssds_bcd.sv -----
// ----------------------------------------------------------------------------
// Load value converter
// Clamps a binary value, splits it into decimal digits and left-aligns them.
// ----------------------------------------------------------------------------
module ssds_bcd #(
	parameter int unsigned DIGIT_COUNT = ssds_pkg::DIGIT_COUNT_DEF
) (
	input  logic [ssds_pkg::VALUE_W-1:0] value,
	output ssds_pkg::conv_t              conv
);

	localparam int unsigned VW        = ssds_pkg::VALUE_W;
	localparam int unsigned ND        = ssds_pkg::BCD_DIGITS;
	localparam int unsigned LIMIT     = ssds_pkg::pow10(DIGIT_COUNT) - 1;
	localparam bit          CAN_CLAMP = LIMIT < ((1 << VW) - 1);
	localparam logic [VW-1:0] LIMIT_V = VW'(LIMIT);

	logic                                     clamped;
	logic [VW-1:0]                            v;
	logic [ssds_pkg::PROD_W-1:0]              prod [ND];
	logic [VW-1:0]                            quot [ND];
	logic [ND-1:0][ssds_pkg::DIGIT_W-1:0]     digit;
	logic [ND-1:0][ssds_pkg::DIGIT_W-1:0]     aligned;
	logic [ssds_pkg::USED_W-1:0]              used;

	assign clamped = CAN_CLAMP && (value > LIMIT_V);
	assign v       = clamped ? LIMIT_V : value;

	// all quotients in parallel, then each digit is q_k - 10*q_(k+1)
	always_comb begin
		for (int k = 0; k < ND; k++) begin
			prod[k] = ssds_pkg::PROD_W'(v) * ssds_pkg::PROD_W'(ssds_pkg::RECIP_MUL[k]);
			quot[k] = VW'(prod[k] >> ssds_pkg::RECIP_SHIFT[k]);
		end
		for (int k = 0; k < ND - 1; k++) begin
			digit[k] = ssds_pkg::DIGIT_W'(quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1)));
		end
		digit[ND-1] = ssds_pkg::DIGIT_W'(quot[ND-1]);
	end

	// zero still shows one digit
	always_comb begin
		used = ssds_pkg::USED_W'(1);
		for (int k = 0; k < ND; k++) begin
			if (digit[k] != '0) begin
				used = ssds_pkg::USED_W'(k + 1);
			end
		end
	end

	// most significant digit goes to position 0
	always_comb begin
		for (int p = 0; p < ND; p++) begin
			aligned[p] = '0;
			for (int k = 0; k < ND; k++) begin
				if (int'(used) == k + p + 1) begin
					aligned[p] = digit[k];
				end
			end
		end
	end

	assign conv.digit   = aligned;
	assign conv.used    = used;
	assign conv.clamped = clamped;

endmodule

// ----- rtl/core/seven_segment_decimal_scanner.sv -----
// ----------------------------------------------------------------------------
// Seven-segment decimal scanner
// Multiplexed drive for a common-cathode display of DIGIT_COUNT digits.
// Input channel "item": cmd 1 loads value (clamped, shown left-aligned in
// decimal), cmd 0 is one refresh tick. Every item transfer yields exactly one
// transfer on "result": active-low digit enables, segments a..g plus decimal
// point, and the over-range flag of the last load.
// The item is registered, converted to decimal digits into the conversion
// stage register, then the scan update is registered into the result
// register that drives result valid. One item is taken every
// cycle; a stalled result stalls all three stages together.
// Registers over APB: dwell_ticks at 0x0, point_mask at 0x4; write only
// while no item is in flight.
// Reset blanks the display, clears the pipeline and sets dwell_ticks to
// 25000 and point_mask to 0.
// ----------------------------------------------------------------------------
`include "seven_segment_decimal_scanner_defines.svh"

module seven_segment_decimal_scanner #(
	parameter int unsigned DIGIT_COUNT = ssds_pkg::DIGIT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssds_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ssds_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ssds_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	ssds_item_if.sink                         item,
	ssds_result_if.source                     result
);

	localparam int unsigned POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int unsigned CMP_W       = (POS_W + 1 > ssds_pkg::USED_W) ?
		POS_W + 1 : ssds_pkg::USED_W;
	localparam int unsigned LOAD_DIGITS = (DIGIT_COUNT < ssds_pkg::BCD_DIGITS) ?
		DIGIT_COUNT : ssds_pkg::BCD_DIGITS;
	localparam int unsigned DW          = ssds_pkg::DIGIT_W;

	// configuration
	logic [ssds_pkg::DWELL_W-1:0]  dwell_ticks_q;
	logic [ssds_pkg::MASK_W-1:0]   point_mask_q;

	// pipeline
	logic                          adv;
	logic                          v_s1, v_s2;
	logic                          cmd_s1, cmd_s2;
	logic [ssds_pkg::VALUE_W-1:0]  value_s1;
	ssds_pkg::conv_t               conv_s1, conv_s2;

	// scan state
	logic [DW-1:0]                 digits_q [DIGIT_COUNT];
	logic [DW-1:0]                 digits_d [DIGIT_COUNT];
	logic [DW-1:0]                 load_digits [DIGIT_COUNT];
	logic [ssds_pkg::USED_W-1:0]   used_q, used_d;
	logic [POS_W-1:0]              scan_q, scan_d;
	logic [ssds_pkg::DWELL_W-1:0]  dwell_q, dwell_d, dwell_inc, limit;
	logic [CMP_W-1:0]              scan_inc;
	logic                          clamp_q, clamp_d;

	// result
	logic                          out_valid_q;
	logic [ssds_pkg::ENABLE_W-1:0] enable_n_d, enable_n_q;
	logic [ssds_pkg::SEG_W-1:0]    segments_d, segments_q;
	logic                          over_range_q;

	// ------------------------------------------------------------------ APB
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= ssds_pkg::DWELL_RESET;
			point_mask_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ssds_pkg::reg_idx_t'(paddr[2]))
				ssds_pkg::REG_DWELL_TICKS: dwell_ticks_q <= pwdata[ssds_pkg::DWELL_W-1:0];
				ssds_pkg::REG_POINT_MASK:  point_mask_q  <= pwdata[ssds_pkg::MASK_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (ssds_pkg::reg_idx_t'(paddr[2]))
			ssds_pkg::REG_DWELL_TICKS: prdata = ssds_pkg::APB_DATA_W'(dwell_ticks_q);
			ssds_pkg::REG_POINT_MASK:  prdata = ssds_pkg::APB_DATA_W'(point_mask_q);
		endcase
	end

	// ------------------------------------------------------------- pipeline
	// all stages move together whenever the result register can take data
	assign adv        = !out_valid_q || result.ready;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= item.valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	ssds_bcd #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_bcd (
		.value (value_s1),
		.conv  (conv_s1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= item.cmd;
			value_s1 <= item.value;
			cmd_s2   <= cmd_s1;
			conv_s2  <= conv_s1;
			if (v_s2) begin
				enable_n_q   <= enable_n_d;
				segments_q   <= segments_d;
				over_range_q <= clamp_d;
			end
		end
	end

	// ----------------------------------------------------------- scan state
	for (genvar p = 0; p < DIGIT_COUNT; p++) begin : g_load
		if (p < ssds_pkg::BCD_DIGITS) begin : g_digit
			assign load_digits[p] = conv_s2.digit[p];
		end else begin : g_blank
			assign load_digits[p] = '0;
		end
	end

	always_comb begin
		digits_d  = digits_q;
		used_d    = used_q;
		scan_d    = scan_q;
		clamp_d   = clamp_q;
		dwell_inc = ssds_pkg::DWELL_W'(dwell_q + 1'b1);
		limit     = (dwell_ticks_q == '0) ? ssds_pkg::DWELL_W'(1) : dwell_ticks_q;
		scan_inc  = CMP_W'(scan_q) + CMP_W'(1);
		dwell_d   = dwell_inc;
		if (cmd_s2) begin
			digits_d = load_digits;
			used_d   = conv_s2.used;
			scan_d   = '0;
			dwell_d  = '0;
			clamp_d  = conv_s2.clamped;
		end else if (dwell_inc >= limit) begin
			dwell_d = '0;
			// wrap after the last used position
			if (used_q != '0) begin
				scan_d = (scan_inc >= CMP_W'(used_q)) ? '0 : POS_W'(scan_inc);
			end
		end
	end

	always_comb begin
		enable_n_d = '1;
		segments_d = '0;
		if (used_d != '0) begin
			segments_d = ssds_pkg::SEG_TABLE[digits_d[scan_d]];
			for (int b = 0; b < ssds_pkg::ENABLE_W; b++) begin
				if (CMP_W'(scan_d) == CMP_W'(b)) begin
					enable_n_d[b] = 1'b0;
					if (point_mask_q[b]) begin
						segments_d = segments_d | ssds_pkg::POINT_BIT;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < DIGIT_COUNT; p++) begin
				digits_q[p] <= '0;
			end
			used_q  <= '0;
			scan_q  <= '0;
			dwell_q <= '0;
			clamp_q <= 1'b0;
		end else if (adv && v_s2) begin
			digits_q <= digits_d;
			used_q   <= used_d;
			scan_q   <= scan_d;
			dwell_q  <= dwell_d;
			clamp_q  <= clamp_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.digit_enable_n = enable_n_q;
	assign result.segments       = segments_q;
	assign result.over_range     = over_range_q;

	// ----------------------------------------------------------- assertions
	`SSDS_ASSERT_IMP(a_scan_in_range, clk, arst_n, used_q != '0, CMP_W'(scan_q) < CMP_W'(used_q))
	`SSDS_ASSERT_IMP(a_scan_blank_home, clk, arst_n, used_q == '0, scan_q == '0)
	`SSDS_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= ssds_pkg::USED_W'(LOAD_DIGITS))
	`SSDS_ASSERT_IMP(a_one_digit_lit, clk, arst_n, out_valid_q, enable_n_q == '1 || $onehot(~enable_n_q))
	`SSDS_ASSERT_NEXT(a_load_home, clk, arst_n, adv && v_s2 && cmd_s2, scan_q == '0 && dwell_q == '0)

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Decimal scanner testbench
// Drives load and tick items into the seven-segment scanner under random
// source and sink stalls. Each item's display drive is predicted locally and
// checked against the result channel in order. Dwell and decimal point
// registers are rewritten over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SHOWN_ERRORS = 10;
	localparam int unsigned DISPLAY_MAX  = 9999;
	localparam logic [15:0] DWELL_AT_RESET = 16'd25000;
	localparam logic [7:0]  DP_SEGMENT     = 8'h80;

	// segments a..g per decimal digit
	localparam logic [7:0] DIGIT_GLYPH [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} scan_cmd_t;

	typedef struct {
		scan_cmd_t                    cmd;
		logic [ssds_pkg::VALUE_W-1:0] value;
	} scan_item_t;

	typedef struct packed {
		logic [ssds_pkg::ENABLE_W-1:0] enable_n;
		logic [ssds_pkg::SEG_W-1:0]    segs;
		logic                          over;
	} drive_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ssds_pkg::APB_ADDR_W-1:0] paddr;
	logic [ssds_pkg::APB_DATA_W-1:0] pwdata;
	logic [ssds_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	ssds_item_if   item_ch();
	ssds_result_if result_ch();

	seven_segment_decimal_scanner dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	scan_item_t  pending_items[$];
	drive_t      expected_drive[$];
	bit          item_taken;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned bad_count;
	int unsigned cycle_count;

	// display model
	logic [15:0]                   cfg_dwell;
	logic [ssds_pkg::MASK_W-1:0]   cfg_points;
	logic [3:0]                    shown_digit [4];
	int unsigned                   used_count;
	int unsigned                   scan_pos;
	logic [15:0]                   dwell_cnt;
	logic                          over_flag;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// advance the display model by one item and queue the drive it produces
	function automatic void step_display(input scan_cmd_t cmd,
		input logic [ssds_pkg::VALUE_W-1:0] val);
		int unsigned v;
		int unsigned n;
		logic [3:0]  rev [4];
		logic [15:0] lim;
		drive_t      d;
		if (cmd == CMD_LOAD) begin
			v = val;
			over_flag = (v > DISPLAY_MAX);
			if (over_flag)
				v = DISPLAY_MAX;
			n = 0;
			for (int i = 0; i < 4; i++)
				rev[i] = 4'd0;
			while (v != 0 && n < 4) begin
				rev[n] = 4'(v % 10);
				v = v / 10;
				n++;
			end
			if (n == 0)
				n = 1;
			for (int i = 0; i < 4; i++)
				shown_digit[i] = (i < n) ? rev[n - 1 - i] : 4'd0;
			used_count = n;
			scan_pos = 0;
			dwell_cnt = 16'd0;
		end else begin
			lim = (cfg_dwell == 16'd0) ? 16'd1 : cfg_dwell;
			dwell_cnt = dwell_cnt + 16'd1;
			if (dwell_cnt >= lim) begin
				dwell_cnt = 16'd0;
				if (used_count != 0) begin
					scan_pos++;
					if (scan_pos >= used_count)
						scan_pos = 0;
				end
			end
		end
		d.enable_n = 4'hF;
		d.segs = 8'h00;
		d.over = over_flag;
		if (used_count != 0) begin
			d.segs = (shown_digit[scan_pos] < 10) ? DIGIT_GLYPH[shown_digit[scan_pos]] : 8'h00;
			d.enable_n = 4'hF & ~(4'b0001 << scan_pos);
			if (cfg_points[scan_pos])
				d.segs = d.segs | DP_SEGMENT;
		end
		expected_drive.push_back(d);
	endfunction

	function automatic logic [ssds_pkg::VALUE_W-1:0] pick_value();
		logic [ssds_pkg::VALUE_W-1:0] v;
		case ($urandom_range(5))
			0: v = '0;
			1: v = ssds_pkg::VALUE_W'($urandom_range(9, 1));
			2: v = ssds_pkg::VALUE_W'($urandom_range(99, 10));
			3: v = ssds_pkg::VALUE_W'($urandom_range(999, 100));
			4: v = ssds_pkg::VALUE_W'($urandom_range(9999, 1000));
			default: v = ssds_pkg::VALUE_W'($urandom_range(16383, 10000));
		endcase
		return v;
	endfunction

	task automatic add_item(input scan_cmd_t cmd, input int unsigned val);
		scan_item_t it;
		it.cmd = cmd;
		it.value = ssds_pkg::VALUE_W'(val);
		pending_items.push_back(it);
	endtask

	task automatic add_random(input int unsigned count, input int unsigned load_pct);
		scan_item_t it;
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(99) < load_pct) begin
				it.cmd = CMD_LOAD;
				it.value = pick_value();
			end else begin
				// tick payload is ignored; keep it noisy
				it.cmd = CMD_TICK;
				it.value = ssds_pkg::VALUE_W'($urandom);
			end
			pending_items.push_back(it);
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_ch.valid || expected_drive.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input ssds_pkg::reg_idx_t idx,
		input logic [ssds_pkg::APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == ssds_pkg::REG_DWELL_TICKS)
			cfg_dwell = data[15:0];
		else
			cfg_points = data[ssds_pkg::MASK_W-1:0];
	endtask

	// wait for the block to empty, then rewrite both registers
	task automatic reconfigure(input logic [15:0] dwell,
		input logic [ssds_pkg::MASK_W-1:0] points);
		drain();
		apb_write(ssds_pkg::REG_DWELL_TICKS, ssds_pkg::APB_DATA_W'(dwell));
		apb_write(ssds_pkg::REG_POINT_MASK, ssds_pkg::APB_DATA_W'(points));
	endtask

	// item source
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			step_display(scan_cmd_t'(item_ch.cmd), item_ch.value);
			void'(pending_items.pop_front());
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_taken) begin
			item_taken = 1'b0;
			if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				item_ch.valid <= 1'b1;
				item_ch.cmd <= pending_items[0].cmd;
				item_ch.value <= pending_items[0].value;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		drive_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_drive.size() == 0) begin
				bad_count++;
				if (bad_count <= SHOWN_ERRORS)
					$display("unexpected result: en_n=%h seg=%h over=%b",
						result_ch.digit_enable_n, result_ch.segments, result_ch.over_range);
			end else begin
				want = expected_drive.pop_front();
				if (result_ch.digit_enable_n !== want.enable_n ||
					result_ch.segments !== want.segs ||
					result_ch.over_range !== want.over) begin
					bad_count++;
					if (bad_count <= SHOWN_ERRORS)
						$display("mismatch: expected en_n=%h seg=%h over=%b, got en_n=%h seg=%h over=%b",
							want.enable_n, want.segs, want.over,
							result_ch.digit_enable_n, result_ch.segments, result_ch.over_range);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = 1'b0;
		item_ch.value = '0;
		result_ch.ready = 1'b0;
		item_taken = 1'b0;
		bad_count = 0;
		cfg_dwell = DWELL_AT_RESET;
		cfg_points = '0;
		for (int i = 0; i < 4; i++)
			shown_digit[i] = 4'd0;
		used_count = 0;
		scan_pos = 0;
		dwell_cnt = 16'd0;
		over_flag = 1'b0;
		src_idle_pct = 33;
		snk_idle_pct = 57;
		// hold reset, then release it at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// blank display before any load, then a single digit
		add_item(CMD_TICK, 0);
		add_item(CMD_TICK, 16383);
		add_item(CMD_LOAD, 7);
		add_item(CMD_TICK, 0);

		// zero dwell advances on every tick; all points lit
		reconfigure(16'd0, 4'hF);
		add_item(CMD_LOAD, 0);
		add_item(CMD_TICK, 0);
		add_item(CMD_LOAD, 9999);
		add_item(CMD_TICK, 0);
		add_item(CMD_TICK, 0);
		add_item(CMD_TICK, 0);
		add_item(CMD_TICK, 0);
		add_item(CMD_LOAD, 10000);
		add_item(CMD_TICK, 0);
		add_item(CMD_LOAD, 16383);
		add_item(CMD_TICK, 0);
		add_item(CMD_LOAD, 1234);
		add_item(CMD_TICK, 0);
		add_item(CMD_TICK, 0);
		add_item(CMD_LOAD, 10);
		add_item(CMD_TICK, 0);
		add_item(CMD_TICK, 0);
		add_item(CMD_LOAD, 100);
		add_item(CMD_TICK, 0);

		reconfigure(16'($urandom_range(4, 1)), 4'($urandom));
		add_random(350, 12);

		src_idle_pct = 57;
		snk_idle_pct = 33;
		reconfigure(16'hFFFF, 4'h0);
		add_random(100, 15);
		reconfigure(16'($urandom_range(6, 1)), 4'($urandom));
		add_random(350, 12);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		reconfigure(16'd1, 4'($urandom));
		add_random(200, 12);
		reconfigure(16'($urandom_range(3, 2)), 4'hF);
		add_random(200, 12);

		drain();
		// catch any stray result
		repeat (8) @(posedge clk);
		if (bad_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
